// File: design/assert_macros.svh
// Assertion macros used by the parser core.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

// Checked only while reset is released.
`define BCP_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked at every edge, reset included.
`define BCP_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

`else

`define BCP_ASSERT(label, prop, msg)
`define BCP_ASSERT_ALWAYS(label, prop, msg)

`endif

`endif

// File: design/bcp_pkg.sv
package bcp_pkg;

    // Parser phases. The three string sections share COUNT, LEN and CHARS.
    typedef enum logic [2:0] {
        PH_HEADER,
        PH_COUNT,
        PH_LEN,
        PH_CHARS,
        PH_CODESIZE,
        PH_CODE,
        PH_TRAIL,
        PH_ERROR
    } phase_t;

    localparam logic [2:0] SEC_HEADER    = 3'd0;
    localparam logic [2:0] SEC_CONSTANTS = 3'd1;
    localparam logic [2:0] SEC_GLOBALS   = 3'd2;
    localparam logic [2:0] SEC_FUNCTIONS = 3'd3;
    localparam logic [2:0] SEC_CODE      = 3'd4;
    localparam logic [2:0] SEC_TRAILING  = 3'd5;

    localparam logic [2:0] ROLE_MAGIC   = 3'd0;
    localparam logic [2:0] ROLE_VERSION = 3'd1;
    localparam logic [2:0] ROLE_FLAGS   = 3'd2;
    localparam logic [2:0] ROLE_COUNT   = 3'd3;
    localparam logic [2:0] ROLE_LENGTH  = 3'd4;
    localparam logic [2:0] ROLE_CHAR    = 3'd5;
    localparam logic [2:0] ROLE_CODE    = 3'd6;
    localparam logic [2:0] ROLE_IGNORED = 3'd7;

    localparam logic [2:0] ST_RUN     = 3'd0;
    localparam logic [2:0] ST_DONE    = 3'd1;
    localparam logic [2:0] ST_FORMAT  = 3'd2;
    localparam logic [2:0] ST_VERSION = 3'd3;
    localparam logic [2:0] ST_TRUNC   = 3'd4;

    localparam logic [7:0] MAGIC_0 = 8'h44;
    localparam logic [7:0] MAGIC_1 = 8'h53;
    localparam logic [7:0] MAGIC_2 = 8'h42;
    localparam logic [7:0] MAGIC_3 = 8'h43;

    localparam logic [7:0] VERSION_MAJOR = 8'd1;
    localparam logic [7:0] VERSION_MINOR = 8'd0;

    localparam logic [2:0] HDR_MAJOR_POS = 3'd4;
    localparam logic [2:0] HDR_MINOR_POS = 3'd5;
    localparam logic [2:0] HDR_LAST_POS  = 3'd7;

    localparam logic [1:0] LAST_STRING_SECTION = 2'd3;

    typedef struct packed {
        logic       end_of_stream;
        logic [7:0] data_byte;
    } in_item_t;

    typedef struct packed {
        logic [2:0]  section;
        logic [2:0]  byte_role;
        logic [31:0] item_index;
        logic [31:0] byte_offset;
        logic [7:0]  payload_byte;
        logic        item_done;
        logic [2:0]  status;
    } result_t;

    function automatic logic [7:0] magic_byte(input logic [1:0] pos);
        logic [7:0] value;
        case (pos)
            2'd0:    value = MAGIC_0;
            2'd1:    value = MAGIC_1;
            2'd2:    value = MAGIC_2;
            default: value = MAGIC_3;
        endcase
        return value;
    endfunction

endpackage

// File: design/bcp_in_reg.sv
module bcp_in_reg (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              s_tvalid,
    output logic              s_tready,
    input  logic [7:0]        s_tdata,
    input  logic              s_tlast,
    input  logic              take,
    output logic              item_valid,
    output bcp_pkg::in_item_t item
);
    import bcp_pkg::*;

    logic     valid_reg;
    logic     valid_next;
    in_item_t item_reg;

    // A new transaction is taken when the stage is empty or drains this cycle.
    assign s_tready   = !valid_reg || take;
    assign valid_next = s_tready ? s_tvalid : valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            item_reg.data_byte     <= s_tdata;
            item_reg.end_of_stream <= s_tlast;
        end
    end

    assign item_valid = valid_reg;
    assign item       = item_reg;

endmodule

// File: design/bcp_parser.sv
module bcp_parser (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              step,
    input  bcp_pkg::in_item_t item,
    output bcp_pkg::result_t  result,
    output bcp_pkg::phase_t   phase
);
    import bcp_pkg::*;

    phase_t      phase_reg, phase_next;
    logic [1:0]  sec_reg, sec_next;
    logic [2:0]  hdr_pos_reg, hdr_pos_next;
    logic [1:0]  fb_reg, fb_next;
    logic [31:0] acc_reg, acc_next;
    logic [31:0] items_reg, items_next;
    logic [31:0] item_reg, item_next;
    logic [31:0] bytes_reg, bytes_next;
    logic        vmis_reg, vmis_next;
    logic [2:0]  err_reg, err_next;

    logic [31:0] acc_or;
    logic [2:0]  err_code;
    logic        complete;
    logic        done;
    logic [2:0]  st_new;

    logic [7:0] b;
    logic       eos;

    assign b      = item.data_byte;
    assign eos    = item.end_of_stream;
    assign acc_or = acc_reg | (32'(b) << {fb_reg, 3'b000});

    // Next state
    always_comb
    begin
        phase_next   = phase_reg;
        sec_next     = sec_reg;
        hdr_pos_next = hdr_pos_reg;
        fb_next      = fb_reg;
        acc_next     = acc_reg;
        items_next   = items_reg;
        item_next    = item_reg;
        bytes_next   = bytes_reg;
        vmis_next    = vmis_reg;
        err_next     = err_reg;
        err_code     = ST_RUN;
        complete     = 1'b0;
        done         = 1'b0;
        st_new       = ST_RUN;

        case (phase_reg)
            PH_HEADER:
            begin
                if (!hdr_pos_reg[2] && b != magic_byte(hdr_pos_reg[1:0]))
                begin
                    err_code = ST_FORMAT;
                end
                if ((hdr_pos_reg == HDR_MAJOR_POS && b != VERSION_MAJOR) ||
                    (hdr_pos_reg == HDR_MINOR_POS && b != VERSION_MINOR))
                begin
                    vmis_next = 1'b1;
                end
                if (hdr_pos_reg == HDR_LAST_POS)
                begin
                    if (vmis_reg)
                    begin
                        err_code = ST_VERSION;
                    end
                    else
                    begin
                        phase_next = PH_COUNT;
                        sec_next   = 2'd1;
                    end
                end
                else
                begin
                    hdr_pos_next = hdr_pos_reg + 3'd1;
                    if (err_code == ST_RUN && eos)
                    begin
                        err_code = ST_FORMAT;
                    end
                end
            end
            PH_COUNT:
            begin
                acc_next = acc_or;
                if (fb_reg == 2'd3)
                begin
                    items_next = acc_or;
                    acc_next   = '0;
                    fb_next    = '0;
                    item_next  = '0;
                    if (acc_or == 32'd0)
                    begin
                        if (sec_reg < LAST_STRING_SECTION)
                        begin
                            sec_next = sec_reg + 2'd1;
                        end
                        else
                        begin
                            phase_next = PH_CODESIZE;
                        end
                    end
                    else
                    begin
                        phase_next = PH_LEN;
                    end
                end
                else
                begin
                    fb_next = fb_reg + 2'd1;
                end
            end
            PH_LEN, PH_CHARS:
            begin
                if (phase_reg == PH_LEN)
                begin
                    if (fb_reg[0])
                    begin
                        bytes_next = {16'd0, acc_or[15:0]};
                        acc_next   = '0;
                        fb_next    = '0;
                        if (acc_or[15:0] == 16'd0)
                        begin
                            done = 1'b1;
                        end
                        else
                        begin
                            phase_next = PH_CHARS;
                        end
                    end
                    else
                    begin
                        acc_next = acc_or;
                        fb_next  = 2'd1;
                    end
                end
                else
                begin
                    acc_next   = acc_reg + 32'd1;
                    bytes_next = bytes_reg - 32'd1;
                    if (bytes_reg == 32'd1)
                    begin
                        done     = 1'b1;
                        acc_next = '0;
                    end
                end
                // The string is finished: step to the next one or the next section.
                if (done)
                begin
                    item_next  = item_reg + 32'd1;
                    items_next = items_reg - 32'd1;
                    if (items_reg == 32'd1)
                    begin
                        if (sec_reg < LAST_STRING_SECTION)
                        begin
                            sec_next   = sec_reg + 2'd1;
                            phase_next = PH_COUNT;
                        end
                        else
                        begin
                            phase_next = PH_CODESIZE;
                        end
                    end
                    else
                    begin
                        phase_next = PH_LEN;
                    end
                end
            end
            PH_CODESIZE:
            begin
                acc_next = acc_or;
                if (fb_reg == 2'd3)
                begin
                    bytes_next = acc_or;
                    acc_next   = '0;
                    fb_next    = '0;
                    if (acc_or == 32'd0)
                    begin
                        done       = 1'b1;
                        complete   = 1'b1;
                        phase_next = PH_TRAIL;
                    end
                    else
                    begin
                        phase_next = PH_CODE;
                    end
                end
                else
                begin
                    fb_next = fb_reg + 2'd1;
                end
            end
            PH_CODE:
            begin
                acc_next   = acc_reg + 32'd1;
                bytes_next = bytes_reg - 32'd1;
                if (bytes_reg == 32'd1)
                begin
                    done       = 1'b1;
                    complete   = 1'b1;
                    acc_next   = '0;
                    phase_next = PH_TRAIL;
                end
            end
            default:
            begin
            end
        endcase

        if (phase_reg != PH_TRAIL && phase_reg != PH_ERROR)
        begin
            if (err_code != ST_RUN)
            begin
                err_next   = err_code;
                phase_next = PH_ERROR;
                st_new     = err_code;
            end
            else if (complete)
            begin
                st_new = ST_DONE;
            end
            else if (eos)
            begin
                err_next   = ST_TRUNC;
                phase_next = PH_ERROR;
                st_new     = ST_TRUNC;
            end
        end
    end

    // Outputs
    always_comb
    begin
        result              = '0;
        result.payload_byte = b;
        result.item_done    = done;
        result.status       = st_new;
        case (phase_reg)
            PH_HEADER:
            begin
                result.section     = SEC_HEADER;
                result.byte_offset = 32'(hdr_pos_reg);
                if (!hdr_pos_reg[2])
                begin
                    result.byte_role = ROLE_MAGIC;
                end
                else if (!hdr_pos_reg[1])
                begin
                    result.byte_role = ROLE_VERSION;
                end
                else
                begin
                    result.byte_role = ROLE_FLAGS;
                end
            end
            PH_COUNT:
            begin
                result.section     = {1'b0, sec_reg};
                result.byte_role   = ROLE_COUNT;
                result.byte_offset = 32'(fb_reg);
            end
            PH_LEN:
            begin
                result.section     = {1'b0, sec_reg};
                result.byte_role   = ROLE_LENGTH;
                result.item_index  = item_reg;
                result.byte_offset = 32'(fb_reg);
            end
            PH_CHARS:
            begin
                result.section     = {1'b0, sec_reg};
                result.byte_role   = ROLE_CHAR;
                result.item_index  = item_reg;
                result.byte_offset = acc_reg;
            end
            PH_CODESIZE:
            begin
                result.section     = SEC_CODE;
                result.byte_role   = ROLE_COUNT;
                result.byte_offset = 32'(fb_reg);
            end
            PH_CODE:
            begin
                result.section     = SEC_CODE;
                result.byte_role   = ROLE_CODE;
                result.byte_offset = acc_reg;
            end
            PH_TRAIL:
            begin
                result.section   = SEC_TRAILING;
                result.byte_role = ROLE_IGNORED;
                result.status    = ST_DONE;
            end
            default:
            begin
                result.section   = SEC_TRAILING;
                result.byte_role = ROLE_IGNORED;
                result.status    = err_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg   <= PH_HEADER;
            sec_reg     <= '0;
            hdr_pos_reg <= '0;
            fb_reg      <= '0;
            acc_reg     <= '0;
            items_reg   <= '0;
            item_reg    <= '0;
            bytes_reg   <= '0;
            vmis_reg    <= 1'b0;
            err_reg     <= ST_RUN;
        end
        else if (step)
        begin
            phase_reg   <= phase_next;
            sec_reg     <= sec_next;
            hdr_pos_reg <= hdr_pos_next;
            fb_reg      <= fb_next;
            acc_reg     <= acc_next;
            items_reg   <= items_next;
            item_reg    <= item_next;
            bytes_reg   <= bytes_next;
            vmis_reg    <= vmis_next;
            err_reg     <= err_next;
        end
    end

    assign phase = phase_reg;

endmodule

// File: design/bcp_out_reg.sv
module bcp_out_reg (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             result_valid,
    input  bcp_pkg::result_t result,
    output logic             advance,
    output logic             m_tvalid,
    input  logic             m_tready,
    output logic [71:0]      m_tdata,
    output logic [8:0]       m_tuser,
    output logic             m_tlast
);
    import bcp_pkg::*;

    logic    valid_reg;
    logic    valid_next;
    result_t result_reg;

    // The register loads whenever it is empty or its transaction completes.
    assign advance    = !valid_reg || m_tready;
    assign valid_next = advance ? result_valid : valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance && result_valid)
        begin
            result_reg <= result;
        end
    end

    assign m_tvalid = valid_reg;
    assign m_tdata  = {result_reg.payload_byte, result_reg.byte_offset, result_reg.item_index};
    assign m_tuser  = {result_reg.status, result_reg.byte_role, result_reg.section};
    assign m_tlast  = result_reg.item_done;

endmodule

// File: design/bytecode_container_parser_core.sv
// Byte-serial parser for a bytecode container stream.
// Input: one byte per transaction on s_tdata, with s_tlast set on the last
// byte of the stream. Output: one tagged transaction per input byte carrying
// section, byte role and status on m_tuser, the string index, the offset and
// the byte itself on m_tdata, and m_tlast when the byte completes a string
// or the code section.
// One input register, then the parser logic and its state counters feed the
// output register, which drives m_tvalid. One byte is accepted per cycle
// while the receiver keeps m_tready high; the parser state counters update
// once per byte.
// Reset clears the parser to the start of the header and empties both
// register stages. An error (bad magic, short stream, bad version or
// truncation) is held until reset; later bytes are tagged as ignored
// and carry the held status. When the receiver holds m_tready low the
// output holds its transaction, the input register fills, and s_tready
// falls until the output drains.
`include "assert_macros.svh"

module bytecode_container_parser_core (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] data_byte
    input  logic        s_tlast,   // end_of_stream
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [71:0] m_tdata,   // [31:0] item_index, [63:32] byte_offset, [71:64] payload_byte
    output logic [8:0]  m_tuser,   // [2:0] section, [5:3] byte_role, [8:6] status
    output logic        m_tlast    // item_done
);
    import bcp_pkg::*;

    logic     advance;
    logic     item_valid;
    in_item_t item;
    result_t  result;
    phase_t   phase;
    logic     done_role_ok;
    logic     trail_clean;

    bcp_in_reg u_in_reg (
        .clk        (clk),
        .rst_n      (rst_n),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tlast    (s_tlast),
        .take       (advance),
        .item_valid (item_valid),
        .item       (item)
    );

    bcp_parser u_parser (
        .clk    (clk),
        .rst_n  (rst_n),
        .step   (item_valid && advance),
        .item   (item),
        .result (result),
        .phase  (phase)
    );

    bcp_out_reg u_out_reg (
        .clk          (clk),
        .rst_n        (rst_n),
        .result_valid (item_valid),
        .result       (result),
        .advance      (advance),
        .m_tvalid     (m_tvalid),
        .m_tready     (m_tready),
        .m_tdata      (m_tdata),
        .m_tuser      (m_tuser),
        .m_tlast      (m_tlast)
    );

    assign done_role_ok = m_tuser[5:3] inside {ROLE_LENGTH, ROLE_CHAR, ROLE_CODE, ROLE_COUNT};
    assign trail_clean  = (m_tuser[5:3] == ROLE_IGNORED) && (m_tdata[63:0] == 64'd0) &&
                          !m_tlast;

    `BCP_ASSERT(a_error_sticks, (phase == PH_ERROR) |=> (phase == PH_ERROR), "error state left")
    `BCP_ASSERT(a_done_role, (m_tvalid && m_tlast) |-> done_role_ok, "item_done on a wrong role")
    `BCP_ASSERT(a_trail_clean, (m_tvalid && m_tuser[2:0] == SEC_TRAILING) |-> trail_clean, "trailing byte not clean")
    `BCP_ASSERT_ALWAYS(a_reset_empty, !rst_n |=> !m_tvalid, "output valid right after reset")

endmodule
